@@ hdl/hskl_pkg.sv @@
// Shared types and constants for the hashed string key lookup block.
`default_nettype none

package hskl_pkg;

  localparam logic [63:0] HASH_BASIS = 64'hcbf29ce484222325;

  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  localparam logic [1:0] STATUS_STORED = 2'd0;
  localparam logic [1:0] STATUS_FULL   = 2'd1;
  localparam logic [1:0] STATUS_HIT    = 2'd2;
  localparam logic [1:0] STATUS_MISS   = 2'd3;

  // Compare results and key a cell hands to its right-hand neighbor.
  typedef struct packed {
    logic        lt;
    logic        eq;
    logic [63:0] key;
  } link_t;

  // Register levels of the radix-4 hit reduction tree.
  function automatic int tree_levels(input int leaves);
    return ($clog2(leaves) + 1) / 2;
  endfunction

endpackage

`default_nettype wire

@@ hdl/hskl_hash.sv @@
// Running 64-bit FNV-1a hash register with one byte folded in per step.
`default_nettype none

module hskl_hash (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        step_i,
  input  wire logic        last_i,
  input  wire logic [7:0]  byte_i,
  output logic      [63:0] hash_o
);

  logic [63:0] running_q;
  logic [63:0] running_d;
  logic [63:0] mix;
  logic [63:0] mul_low;

  assign mix = running_q ^ {56'd0, byte_i};

  // prime = 2^40 + 0x1b3, 0x1b3 = 256 + 128 + 32 + 16 + 2 + 1
  assign mul_low = (mix << 8) + (mix << 7) + (mix << 5) + (mix << 4) + (mix << 1) + mix;
  assign hash_o  = (mix << 40) + mul_low;

  always_comb begin
    running_d = running_q;
    if (step_i) begin
      running_d = last_i ? hskl_pkg::HASH_BASIS : hash_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= hskl_pkg::HASH_BASIS;
    end else begin
      running_q <= running_d;
    end
  end

endmodule

`default_nettype wire

@@ hdl/hskl_cell.sv @@
// One slot of the sorted key chain: holds a key and value, compares, shifts right.
`default_nettype none

module hskl_cell #(
  parameter int ValueWidth = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  occ_i,
  input  wire logic                  ins_i,
  input  wire logic [63:0]           key_i,
  input  wire logic [ValueWidth-1:0] value_i,
  input  wire hskl_pkg::link_t       prev_i,
  input  wire logic [ValueWidth-1:0] prev_value_i,
  output hskl_pkg::link_t            link_o,
  output logic      [ValueWidth-1:0] value_o,
  output logic      [ValueWidth:0]   leaf_o
);

  logic [63:0]           key_q;
  logic [ValueWidth-1:0] value_q;
  logic                  lt;
  logic                  eq;

  assign lt = occ_i && ($signed(key_i) < $signed(key_q));
  assign eq = occ_i && (key_q == key_i);

  always_ff @(posedge clk_i) begin
    if (ins_i) begin
      if (prev_i.lt) begin
        key_q   <= prev_i.key;
        value_q <= prev_value_i;
      end else if (lt || !occ_i) begin
        key_q   <= key_i;
        value_q <= value_i;
      end
    end
  end

  assign link_o.lt  = lt;
  assign link_o.eq  = eq;
  assign link_o.key = key_q;
  assign value_o    = value_q;

  // equal keys sit together; only the leftmost of a run reports
  assign leaf_o = (eq && !prev_i.eq) ? {1'b1, value_q} : '0;

endmodule

`default_nettype wire

@@ hdl/hskl_ortree.sv @@
// Registered radix-4 OR tree that gathers the single hit leaf to a root.
`default_nettype none

module hskl_ortree #(
  parameter int Leaves = 256,
  parameter int Width  = 17
) (
  input  wire logic             clk_i,
  input  wire logic [Width-1:0] leaf_i [Leaves],
  output logic      [Width-1:0] root_o
);

  localparam int Levels = hskl_pkg::tree_levels(Leaves);
  localparam int Pad    = 1 << (2 * Levels);
  localparam int Inner  = (Pad - 1) / 3;

  wire  [Width-1:0] tree [Inner + Pad];
  logic [Width-1:0] node_q [Inner];

  for (genvar k = 0; k < Pad; k++) begin : g_leaf
    if (k < Leaves) begin : g_used
      assign tree[Inner + k] = leaf_i[k];
    end else begin : g_pad
      assign tree[Inner + k] = '0;
    end
  end

  for (genvar j = 0; j < Inner; j++) begin : g_node
    assign tree[j] = node_q[j];
    always_ff @(posedge clk_i) begin
      node_q[j] <= tree[4*j+1] | tree[4*j+2] | tree[4*j+3] | tree[4*j+4];
    end
  end

  assign root_o = node_q[0];

endmodule

`default_nettype wire

@@ hdl/hashed_string_key_lookup_core.sv @@
// Top level: byte hashing, sorted key cell chain, hit tree and result register.
//
//  channel | direction | handshake                | fields
//  in      | input     | in_valid_i / in_stall_o  | kind, char_byte, last_byte, entry_value
//  out     | output    | out_valid_o / out_stall_i| status, found_value, string_hash
//
// A byte that is not the last of its string does not stall the input.
// A final load byte moves the block to EXEC, where the whole cell chain inserts in parallel.
// A final lookup byte moves through EXEC and then LOOK, which waits out the
// L = ceil(log4(TABLE_DEPTH)) register levels of the hit tree (4 at 256 entries).
// Reset empties the table at once through the entry count; no clearing pass.
// A held result holds back only the next final byte's result; bytes up to it keep flowing.
`default_nettype none

module hashed_string_key_lookup_core #(
  parameter int TABLE_DEPTH = 256,
  parameter int VALUE_WIDTH = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        kind_i,
  input  wire logic [7:0]  char_byte_i,
  input  wire logic        last_byte_i,
  input  wire logic [15:0] entry_value_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic      [1:0]  status_o,
  output logic      [15:0] found_value_o,
  output logic      [63:0] string_hash_o
);

  localparam int Levels     = hskl_pkg::tree_levels(TABLE_DEPTH);
  localparam int CountWidth = $clog2(TABLE_DEPTH + 1);
  localparam int CntWidth   = $clog2(Levels + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_LOOK = 2'd2;

  logic [1:0]             state_q, state_d;
  logic [CountWidth-1:0]  count_q;
  logic [CntWidth-1:0]    cnt_q, cnt_d;
  logic [63:0]            key_q;
  logic                   kind_q;
  logic [VALUE_WIDTH-1:0] val_q;
  logic                   out_valid_q;
  logic [1:0]             status_q, status_d;
  logic [15:0]            found_q, found_d;
  logic [63:0]            hash_out_q;

  logic                   in_acc;
  logic                   out_free;
  logic                   full;
  logic                   ins;
  logic                   out_wr;
  logic [63:0]            hash_next;
  logic [31:0]            ev_ext;
  logic [31:0]            root_ext;
  logic [VALUE_WIDTH:0]   root;

  hskl_pkg::link_t        link      [TABLE_DEPTH];
  hskl_pkg::link_t        prev_link [TABLE_DEPTH];
  logic [VALUE_WIDTH-1:0] cell_val  [TABLE_DEPTH];
  logic [VALUE_WIDTH-1:0] prev_val  [TABLE_DEPTH];
  logic [VALUE_WIDTH:0]   leaf      [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] occ;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign full       = (count_q == CountWidth'(TABLE_DEPTH));
  assign ev_ext     = 32'(entry_value_i);

  hskl_hash u_hash (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (in_acc),
    .last_i (last_byte_i),
    .byte_i (char_byte_i),
    .hash_o (hash_next)
  );

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    assign occ[i] = (CountWidth'(i) < count_q);
    if (i == 0) begin : g_head
      assign prev_link[i] = '0;
      assign prev_val[i]  = '0;
    end else begin : g_body
      assign prev_link[i] = link[i-1];
      assign prev_val[i]  = cell_val[i-1];
    end
    hskl_cell #(
      .ValueWidth (VALUE_WIDTH)
    ) u_cell (
      .clk_i        (clk_i),
      .occ_i        (occ[i]),
      .ins_i        (ins),
      .key_i        (key_q),
      .value_i      (val_q),
      .prev_i       (prev_link[i]),
      .prev_value_i (prev_val[i]),
      .link_o       (link[i]),
      .value_o      (cell_val[i]),
      .leaf_o       (leaf[i])
    );
  end

  hskl_ortree #(
    .Leaves (TABLE_DEPTH),
    .Width  (VALUE_WIDTH + 1)
  ) u_tree (
    .clk_i  (clk_i),
    .leaf_i (leaf),
    .root_o (root)
  );

  assign root_ext = 32'(root[VALUE_WIDTH-1:0]);

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    ins      = 1'b0;
    out_wr   = 1'b0;
    status_d = hskl_pkg::STATUS_STORED;
    found_d  = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && last_byte_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (kind_q == hskl_pkg::KIND_LOAD) begin
          if (out_free) begin
            out_wr   = 1'b1;
            ins      = !full;
            status_d = full ? hskl_pkg::STATUS_FULL : hskl_pkg::STATUS_STORED;
            state_d  = ST_IDLE;
          end
        end else begin
          cnt_d   = CntWidth'(Levels - 1);
          state_d = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (cnt_q != '0) begin
          cnt_d = cnt_q - 1'b1;
        end else if (out_free) begin
          out_wr   = 1'b1;
          status_d = root[VALUE_WIDTH] ? hskl_pkg::STATUS_HIT : hskl_pkg::STATUS_MISS;
          found_d  = root[VALUE_WIDTH] ? root_ext[15:0] : 16'd0;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (ins) begin
        count_q <= count_q + 1'b1;
      end
      if (out_wr) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && last_byte_i) begin
      key_q  <= hash_next;
      kind_q <= kind_i;
      val_q  <= ev_ext[VALUE_WIDTH-1:0];
    end
    if (out_wr) begin
      status_q   <= status_d;
      found_q    <= found_d;
      hash_out_q <= key_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign found_value_o = found_q;
  assign string_hash_o = hash_out_q;

endmodule

`default_nettype wire

@@ hdl/hskl_check.sv @@
// Port-level checker for the lookup core, bound to the top level.
`default_nettype none

module hskl_check (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic        last_byte_i,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [1:0]  status_o,
  input wire logic [15:0] found_value_o,
  input wire logic [63:0] string_hash_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o)
      && $stable(found_value_o) && $stable(string_hash_o))
    else $error("held result item changed");

  a_found_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != hskl_pkg::STATUS_HIT) |-> found_value_o == 16'd0)
    else $error("found_value nonzero without a hit");

  a_final_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && last_byte_i |=> in_stall_o)
    else $error("final byte did not stall the input");

  a_byte_flows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !last_byte_i |=> !in_stall_o)
    else $error("non-final byte stalled the input");

  a_no_stall_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !in_stall_o && !out_valid_o)
    else $error("block busy after reset");

endmodule

bind hashed_string_key_lookup_core hskl_check u_hskl_check (.*);

`default_nettype wire
